// ----- hw/rtl/evr_pkg.sv -----
// Shared types, constants and helpers for the Euler-angle vector rotation core.
`timescale 1ns / 1ps
`default_nettype none
package evr_pkg;

  localparam int COORD_WIDTH        = 32;
  localparam int ANGLE_WIDTH        = 16;
  localparam int TRIG_FRACTION_BITS = 16;

  // Q30 sine datapath
  localparam int QBITS  = 30;
  localparam int FW     = ANGLE_WIDTH - 2;  // quarter-turn fraction bits
  localparam int XW     = 31;               // radians, Q1.30 unsigned
  localparam int X2W    = 32;               // x^2, Q30 unsigned
  localparam int PW     = 32;               // Horner product
  localparam int RW     = 32;               // reciprocal constant
  localparam int DW     = 9;                // Horner divisor
  localparam int RECIP_SHIFT  = 34;
  localparam int HORNER_STEPS = 8;

  localparam logic [XW-1:0] HALF_PI_Q30 = XW'(1686629713);
  localparam logic [XW-1:0] QONE        = XW'(1) << QBITS;

  // (2k)(2k+1) for k = 8 down to 1, and floor(2^34 / divisor)
  localparam logic [DW-1:0] HORNER_DIV [HORNER_STEPS] = '{
    9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6};
  localparam logic [RW-1:0] HORNER_RECIP [HORNER_STEPS] = '{
    32'd63161283, 32'd81808900, 32'd110127366, 32'd156180628,
    32'd238609294, 32'd409044504, 32'd858993459, 32'd2863311530};

  localparam int SIN_LAT = 2 + 3 * HORNER_STEPS + 1;
  localparam int MAT_LAT = 3;
  localparam int ROW_LAT = 3;
  localparam int LAT     = SIN_LAT + MAT_LAT + ROW_LAT;

  localparam int TW = TRIG_FRACTION_BITS + 2;  // signed trig value
  localparam int MW = TRIG_FRACTION_BITS + 3;  // signed matrix entry

  typedef logic [TRIG_FRACTION_BITS:0]      usin_t;
  typedef logic signed [TW-1:0]             trig_t;
  typedef logic signed [MW-1:0]             ment_t;
  typedef logic signed [COORD_WIDTH-1:0]    coord_t;
  typedef logic [ANGLE_WIDTH-1:0]           angle_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    QUAD_FIRST, QUAD_SECOND, QUAD_THIRD, QUAD_FOURTH
  } quad_e;

  typedef struct packed {
    quad_e quad;
    usin_t sin_f;   // quarter sine of f
    usin_t sin_c;   // quarter sine of (quarter - f)
  } quarter_t;

  typedef ment_t [2:0]  mrow_t;
  typedef mrow_t [2:0]  matrix_t;
  typedef coord_t [2:0] vec_t;

  localparam logic signed [2*MW-1:0] FMUL_HALF = (2*MW)'(1) << (TRIG_FRACTION_BITS - 1);

  // product of two trig-scale values, rounded half up
  function automatic ment_t fmul(input ment_t a, input ment_t b);
    logic signed [2*MW-1:0] p;
    p = a * b + FMUL_HALF;
    return MW'(p >>> TRIG_FRACTION_BITS);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/evr_if.sv -----
// Valid/ready channel interfaces for input and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface evr_in_if;
  logic                valid;
  logic                ready;
  evr_pkg::coord_t     vec_x;
  evr_pkg::coord_t     vec_y;
  evr_pkg::coord_t     vec_z;
  logic signed [evr_pkg::ANGLE_WIDTH-1:0] angle_x;
  logic signed [evr_pkg::ANGLE_WIDTH-1:0] angle_y;
  logic signed [evr_pkg::ANGLE_WIDTH-1:0] angle_z;

  modport source (output valid, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                  input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                  output ready);
endinterface

interface evr_out_if;
  logic            valid;
  logic            ready;
  evr_pkg::coord_t rot_x;
  evr_pkg::coord_t rot_y;
  evr_pkg::coord_t rot_z;
  logic            saturated;

  modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/evr_qsin.sv -----
// Pipelined quarter-wave sine: radian scaling, Horner series, rounding.
`timescale 1ns / 1ps
`default_nettype none
module evr_qsin (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [evr_pkg::FW:0] f_i,
  output evr_pkg::usin_t           sin_o
);

  localparam int NS = evr_pkg::HORNER_STEPS;

  logic [evr_pkg::FW+evr_pkg::XW:0] fx;
  logic [evr_pkg::XW-1:0]  x0_q, x1_q;
  logic [evr_pkg::X2W-1:0] x2_q;
  logic [2*evr_pkg::XW-1:0] xx;

  assign fx = f_i * evr_pkg::HALF_PI_Q30;
  assign xx = x0_q * x0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q <= evr_pkg::XW'(fx >> evr_pkg::FW);
      x1_q <= x0_q;
      x2_q <= evr_pkg::X2W'(xx >> evr_pkg::QBITS);
    end
  end

  // per Horner step: A multiply, B reciprocal multiply, C correct and subtract
  logic [evr_pkg::XW-1:0]  xa_q [NS], xb_q [NS], xc_q [NS];
  logic [evr_pkg::X2W-1:0] ya_q [NS], yb_q [NS], yc_q [NS];
  logic [evr_pkg::PW-1:0]  pa_q [NS], pb_q [NS];
  logic [evr_pkg::PW+evr_pkg::RW-1:0] pm_q [NS];
  logic [evr_pkg::XW-1:0]  s_q [NS];

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [evr_pkg::XW-1:0]  s_in, x_in;
    logic [evr_pkg::X2W-1:0] y_in;
    logic [evr_pkg::X2W+evr_pkg::XW-1:0] prod;
    logic [evr_pkg::PW-1:0] q0, rem, q;

    if (j == 0) begin : g_first
      assign s_in = evr_pkg::QONE;
      assign x_in = x1_q;
      assign y_in = x2_q;
    end else begin : g_next
      assign s_in = s_q[j-1];
      assign x_in = xc_q[j-1];
      assign y_in = yc_q[j-1];
    end

    assign prod = y_in * s_in;

    always_comb begin
      q0  = evr_pkg::PW'(pm_q[j] >> evr_pkg::RECIP_SHIFT);
      rem = pb_q[j] - evr_pkg::PW'(q0 * evr_pkg::HORNER_DIV[j]);
      q   = (rem >= evr_pkg::PW'(evr_pkg::HORNER_DIV[j])) ? q0 + 1'b1 : q0;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[j] <= evr_pkg::PW'(prod >> evr_pkg::QBITS);
        xa_q[j] <= x_in;
        ya_q[j] <= y_in;
        pm_q[j] <= pa_q[j] * evr_pkg::HORNER_RECIP[j];
        pb_q[j] <= pa_q[j];
        xb_q[j] <= xa_q[j];
        yb_q[j] <= ya_q[j];
        s_q[j]  <= evr_pkg::QONE - evr_pkg::XW'(q);
        xc_q[j] <= xb_q[j];
        yc_q[j] <= yb_q[j];
      end
    end
  end

  logic [2*evr_pkg::XW-1:0] fp;
  logic [evr_pkg::XW-1:0]   fr;
  evr_pkg::usin_t           sin_q;

  assign fp = xc_q[NS-1] * s_q[NS-1];
  assign fr = evr_pkg::XW'(fp >> evr_pkg::QBITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= evr_pkg::usin_t'((fr + (evr_pkg::XW'(1) << (29 - evr_pkg::TRIG_FRACTION_BITS)))
                                >> (evr_pkg::QBITS - evr_pkg::TRIG_FRACTION_BITS));
    end
  end

  assign sin_o = sin_q;

endmodule
`default_nettype wire

// ----- hw/rtl/evr_mat.sv -----
// Quadrant sign mapping and rotation matrix build, three stages.
`timescale 1ns / 1ps
`default_nettype none
module evr_mat (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  evr_pkg::quarter_t [2:0] q_i,
  output evr_pkg::matrix_t       m_o
);

  evr_pkg::ment_t sn_d [3], cs_d [3];
  evr_pkg::ment_t sn_q [3], cs_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      evr_pkg::ment_t a, b;
      a = evr_pkg::ment_t'({2'b00, q_i[i].sin_f});
      b = evr_pkg::ment_t'({2'b00, q_i[i].sin_c});
      case (q_i[i].quad)
        evr_pkg::QUAD_FIRST:  begin sn_d[i] = a;  cs_d[i] = b;  end
        evr_pkg::QUAD_SECOND: begin sn_d[i] = b;  cs_d[i] = -a; end
        evr_pkg::QUAD_THIRD:  begin sn_d[i] = -a; cs_d[i] = -b; end
        default:              begin sn_d[i] = -b; cs_d[i] = a;  end
      endcase
    end
  end

  // index 0 = x, 1 = y, 2 = z
  evr_pkg::ment_t sxsy_q, cxsy_q, cxsz_q, cxcz_q, sxsz_q, sxcz_q, sz1_q, cz1_q;
  evr_pkg::ment_t m00_q, m01_q, m02_q, m12_q, m22_q;
  evr_pkg::matrix_t m_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sn_q[i] <= sn_d[i];
        cs_q[i] <= cs_d[i];
      end
      sxsy_q   <= evr_pkg::fmul(sn_q[0], sn_q[1]);
      cxsy_q   <= evr_pkg::fmul(cs_q[0], sn_q[1]);
      cxsz_q   <= evr_pkg::fmul(cs_q[0], sn_q[2]);
      cxcz_q   <= evr_pkg::fmul(cs_q[0], cs_q[2]);
      sxsz_q   <= evr_pkg::fmul(sn_q[0], sn_q[2]);
      sxcz_q   <= evr_pkg::fmul(sn_q[0], cs_q[2]);
      sz1_q    <= sn_q[2];
      cz1_q    <= cs_q[2];
      m00_q    <= evr_pkg::fmul(cs_q[1], cs_q[2]);
      m01_q    <= evr_pkg::fmul(cs_q[1], sn_q[2]);
      m02_q    <= -sn_q[1];
      m12_q    <= evr_pkg::fmul(sn_q[0], cs_q[1]);
      m22_q    <= evr_pkg::fmul(cs_q[0], cs_q[1]);

      m_q[0][0] <= m00_q;
      m_q[0][1] <= m01_q;
      m_q[0][2] <= m02_q;
      m_q[1][0] <= evr_pkg::fmul(sxsy_q, cz1_q) - cxsz_q;
      m_q[1][1] <= evr_pkg::fmul(sxsy_q, sz1_q) + cxcz_q;
      m_q[1][2] <= m12_q;
      m_q[2][0] <= evr_pkg::fmul(cxsy_q, cz1_q) + sxsz_q;
      m_q[2][1] <= evr_pkg::fmul(cxsy_q, sz1_q) - sxcz_q;
      m_q[2][2] <= m22_q;
    end
  end

  assign m_o = m_q;

endmodule
`default_nettype wire

// ----- hw/rtl/evr_row.sv -----
// One matrix row times the vector: products, sum, round and saturate.
`timescale 1ns / 1ps
`default_nettype none
module evr_row (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  evr_pkg::mrow_t      m_i,
  input  evr_pkg::vec_t       v_i,
  output evr_pkg::coord_t     res_o,
  output logic                sat_o
);

  localparam int PRW = evr_pkg::MW + evr_pkg::COORD_WIDTH;
  localparam int ACW = PRW + 2;
  localparam int SHW = ACW - evr_pkg::TRIG_FRACTION_BITS;
  localparam logic signed [ACW-1:0] HALF = ACW'(1) << (evr_pkg::TRIG_FRACTION_BITS - 1);
  localparam logic signed [SHW-1:0] TOP  = SHW'(evr_pkg::COORD_MAX);
  localparam logic signed [SHW-1:0] BOT  = SHW'(evr_pkg::COORD_MIN);

  logic signed [PRW-1:0] pr_q [3];
  logic signed [ACW-1:0] acc_q;
  logic signed [SHW-1:0] sh;
  evr_pkg::coord_t       res_q;
  logic                  sat_q;

  assign sh = SHW'(acc_q >>> evr_pkg::TRIG_FRACTION_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= m_i[i] * v_i[i];
      end
      acc_q <= ACW'(pr_q[0]) + ACW'(pr_q[1]) + ACW'(pr_q[2]) + HALF;
      if (sh > TOP) begin
        res_q <= evr_pkg::COORD_MAX;
        sat_q <= 1'b1;
      end else if (sh < BOT) begin
        res_q <= evr_pkg::COORD_MIN;
        sat_q <= 1'b1;
      end else begin
        res_q <= evr_pkg::coord_t'(sh);
        sat_q <= 1'b0;
      end
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule
`default_nettype wire

// ----- hw/rtl/euler_angle_vector_rotation_core.sv -----
// Top level: Euler-angle vector rotation pipeline.
//
//   channel   dir   beat contents
//   in_i      in    vec_x/y/z (Q15.16), angle_x/y/z (binary angle)
//   out_o     out   rot_x/y/z (Q15.16, clamped), saturated
//
// One beat per clock while the output is not stalled; each beat passes through the Horner
// sine pipeline, then the matrix build, then the row products and saturation.
// Reset clears only the valid bits of the stages.
// When the last stage holds a beat that is not taken, the whole pipeline
// holds and in_i.ready drops; no beat is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module euler_angle_vector_rotation_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  evr_in_if.sink     in_i,
  evr_out_if.source  out_o
);

  localparam int LAT     = evr_pkg::LAT;
  localparam int SIN_LAT = evr_pkg::SIN_LAT;
  localparam int VEC_DLY = SIN_LAT + evr_pkg::MAT_LAT;

  logic             en;
  logic [LAT-1:0]   vld_q;

  assign en          = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  evr_pkg::angle_t ang [3];
  assign ang[0] = evr_pkg::angle_t'(in_i.angle_x);
  assign ang[1] = evr_pkg::angle_t'(in_i.angle_y);
  assign ang[2] = evr_pkg::angle_t'(in_i.angle_z);

  evr_pkg::quad_e [2:0]     quad_dly_q [SIN_LAT];
  evr_pkg::vec_t            vec_dly_q  [VEC_DLY];
  evr_pkg::quarter_t [2:0]  qtr;

  for (genvar g = 0; g < 3; g++) begin : g_ang
    logic [evr_pkg::FW:0] f_a, f_b;
    assign f_a = {1'b0, ang[g][evr_pkg::FW-1:0]};
    assign f_b = ((evr_pkg::FW+1)'(1) << evr_pkg::FW) - f_a;

    evr_qsin u_sin_a (.clk_i(clk_i), .en_i(en), .f_i(f_a), .sin_o(qtr[g].sin_f));
    evr_qsin u_sin_b (.clk_i(clk_i), .en_i(en), .f_i(f_b), .sin_o(qtr[g].sin_c));

    assign qtr[g].quad = quad_dly_q[SIN_LAT-1][g];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int g = 0; g < 3; g++) begin
        quad_dly_q[0][g] <= evr_pkg::quad_e'(ang[g][evr_pkg::ANGLE_WIDTH-1 -: 2]);
      end
      for (int i = 1; i < SIN_LAT; i++) begin
        quad_dly_q[i] <= quad_dly_q[i-1];
      end
      vec_dly_q[0] <= {in_i.vec_z, in_i.vec_y, in_i.vec_x};
      for (int i = 1; i < VEC_DLY; i++) begin
        vec_dly_q[i] <= vec_dly_q[i-1];
      end
    end
  end

  evr_pkg::matrix_t mat;
  evr_pkg::coord_t  res [3];
  logic [2:0]       sat;

  evr_mat u_mat (.clk_i(clk_i), .en_i(en), .q_i(qtr), .m_o(mat));

  for (genvar r = 0; r < 3; r++) begin : g_row
    evr_row u_row (
      .clk_i (clk_i),
      .en_i  (en),
      .m_i   (mat[r]),
      .v_i   (vec_dly_q[VEC_DLY-1]),
      .res_o (res[r]),
      .sat_o (sat[r])
    );
  end

  assign out_o.valid     = vld_q[LAT-1];
  assign out_o.rot_x     = res[0];
  assign out_o.rot_y     = res[1];
  assign out_o.rot_z     = res[2];
  assign out_o.saturated = |sat;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during stall");

  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input blocked without a stalled result");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.saturated) |->
      (out_o.rot_x == evr_pkg::COORD_MAX || out_o.rot_x == evr_pkg::COORD_MIN ||
       out_o.rot_y == evr_pkg::COORD_MAX || out_o.rot_y == evr_pkg::COORD_MIN ||
       out_o.rot_z == evr_pkg::COORD_MAX || out_o.rot_z == evr_pkg::COORD_MIN))
    else $error("saturated flag without a clamped component");

endmodule
`default_nettype wire
